/* rtl/power_energy_window_logger_assert.svh */
// Assertion macros for the power energy window logger checker
`ifndef POWER_ENERGY_WINDOW_LOGGER_ASSERT_SVH
`define POWER_ENERGY_WINDOW_LOGGER_ASSERT_SVH

// implication checked on every clock edge outside reset
`define PEWL_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pewl check failed");

// next-cycle implication
`define PEWL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pewl check failed");

`endif

/* rtl/pewl_pkg.sv */
// Package: types, constants and tables shared by the logger modules
`timescale 1ns / 1ps
package pewl_pkg;

    localparam logic [1:0] KIND_DISPLAY = 2'd0;
    localparam logic [1:0] KIND_LOG     = 2'd1;
    localparam logic [1:0] KIND_BUTTON  = 2'd2;

    localparam logic [0:0] OP_SAMPLE = 1'b0;
    localparam logic [0:0] OP_BUTTON = 1'b1;

    // APB byte addresses of the configuration registers
    localparam logic [2:0] ADDR_DISP_INTERVAL = 3'd0;
    localparam logic [2:0] ADDR_LONG_PRESS    = 3'd4;

    localparam logic [15:0] DISP_INTERVAL_RESET = 16'd500;
    localparam logic [15:0] LONG_PRESS_RESET    = 16'd400;
    localparam logic [31:0] LOG_INTERVAL_RESET  = 32'd500;

    localparam int IN_DATA_W  = 113;
    localparam int OUT_DATA_W = 208;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BUTTON,
        ST_EMUL,
        ST_EACC,
        ST_CHECK,
        ST_DIV_START,
        ST_DIV_RUN,
        ST_FINISH,
        ST_OUT,
        ST_WAIT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic       load_item;
        logic       do_button;
        logic       energy_mul;
        logic       energy_acc;
        logic       accumulate;
        logic       div_start;
        logic [1:0] div_sel;     // which sum: bus, shunt, current
        logic       win_log;     // 0 display, 1 log
        logic       finish_mul;
        logic       build_out;
        logic       last;
        logic       clear_win;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_button;
        logic disp_due;
        logic log_due;
        logic logging;
        logic div_done;
    } stat_t;

    function automatic logic [31:0] interval_lookup(input logic [2:0] idx);
        logic [31:0] r;
        begin
            case (idx)
                3'd0: r = 32'd500;
                3'd1: r = 32'd1000;
                3'd2: r = 32'd5000;
                3'd3: r = 32'd10000;
                3'd4: r = 32'd30000;
                3'd5: r = 32'd60000;
                3'd6: r = 32'd300000;
                3'd7: r = 32'd600000;
                default: r = 32'd500;
            endcase
            interval_lookup = r;
        end
    endfunction

endpackage

/* rtl/pewl_div.sv */
// Restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module pewl_div #(
    parameter int NUM_W = 48
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] numer,
    input  logic [31:0]      denom,
    output logic             done,
    output logic [NUM_W-1:0] quot
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quot_reg, quot_next;
    logic [32:0]      rem_reg, rem_next;
    logic [31:0]      den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic [32:0]      trial;

    always_comb
    begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {rem_reg[31:0], quot_reg[NUM_W-1]};
        if (start)
        begin
            quot_next = numer;
            rem_next  = '0;
            den_next  = denom;
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next  = trial - {1'b0, den_reg};
                quot_next = {quot_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = trial;
                quot_next = {quot_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
    end

    assign done = !busy_reg && !start;
    assign quot = quot_reg;
endmodule

/* rtl/pewl_ctrl.sv */
// Controller state machine sequencing one word through the datapath
`timescale 1ns / 1ps
module pewl_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_fire,
    input  logic            out_busy,
    input  pewl_pkg::stat_t stat,
    output logic            in_ready,
    output pewl_pkg::cmd_t  cmd
);
    pewl_pkg::state_t state_reg, state_next;
    logic       win_reg, win_next;
    logic [1:0] sel_reg, sel_next;

    always_comb
    begin
        state_next = state_reg;
        win_next   = win_reg;
        sel_next   = sel_reg;
        case (state_reg)
            pewl_pkg::ST_IDLE:
                if (in_fire)
                    state_next = pewl_pkg::ST_WAIT;
            pewl_pkg::ST_WAIT:
                state_next = stat.is_button ? pewl_pkg::ST_BUTTON : pewl_pkg::ST_EMUL;
            pewl_pkg::ST_BUTTON:
                if (!out_busy)
                    state_next = pewl_pkg::ST_IDLE;
            pewl_pkg::ST_EMUL:
                state_next = pewl_pkg::ST_EACC;
            pewl_pkg::ST_EACC:
            begin
                state_next = pewl_pkg::ST_CHECK;
                win_next   = 1'b0;
            end
            pewl_pkg::ST_CHECK:
            begin
                sel_next = 2'd0;
                if (!win_reg)
                begin
                    if (stat.disp_due)
                        state_next = pewl_pkg::ST_DIV_START;
                    else
                        win_next = 1'b1;
                end
                else if (stat.log_due && stat.logging)
                    state_next = pewl_pkg::ST_DIV_START;
                else
                    state_next = pewl_pkg::ST_IDLE;
            end
            pewl_pkg::ST_DIV_START:
                state_next = pewl_pkg::ST_DIV_RUN;
            pewl_pkg::ST_DIV_RUN:
                if (stat.div_done)
                begin
                    if (sel_reg == 2'd2)
                        state_next = pewl_pkg::ST_FINISH;
                    else
                    begin
                        sel_next   = sel_reg + 2'd1;
                        state_next = pewl_pkg::ST_DIV_START;
                    end
                end
            pewl_pkg::ST_FINISH:
                state_next = pewl_pkg::ST_OUT;
            pewl_pkg::ST_OUT:
                if (!out_busy)
                begin
                    if (!win_reg)
                    begin
                        win_next   = 1'b1;
                        state_next = pewl_pkg::ST_CHECK;
                    end
                    else
                        state_next = pewl_pkg::ST_IDLE;
                end
            default:
                state_next = pewl_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        cmd.div_sel = sel_reg;
        cmd.win_log = win_reg;
        in_ready   = 1'b0;
        case (state_reg)
            pewl_pkg::ST_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.load_item = in_fire;
            end
            pewl_pkg::ST_BUTTON:
                if (!out_busy)
                begin
                    cmd.do_button = 1'b1;
                    cmd.build_out = 1'b1;
                    cmd.last      = 1'b1;
                end
            pewl_pkg::ST_EMUL:
            begin
                cmd.energy_mul = 1'b1;
                cmd.accumulate = 1'b1;
            end
            pewl_pkg::ST_EACC:
                cmd.energy_acc = 1'b1;
            pewl_pkg::ST_CHECK:
                // a log window that expires with logging off just restarts
                if (win_reg && stat.log_due && !stat.logging)
                    cmd.clear_win = 1'b1;
            pewl_pkg::ST_DIV_START:
                cmd.div_start = 1'b1;
            pewl_pkg::ST_FINISH:
                cmd.finish_mul = 1'b1;
            pewl_pkg::ST_OUT:
                if (!out_busy)
                begin
                    cmd.build_out = 1'b1;
                    cmd.clear_win = 1'b1;
                    cmd.last      = win_reg || !(stat.log_due && stat.logging);
                end
            default:
                in_ready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pewl_pkg::ST_IDLE;
            win_reg   <= 1'b0;
            sel_reg   <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            win_reg   <= win_next;
            sel_reg   <= sel_next;
        end
    end
endmodule

/* rtl/pewl_datapath.sv */
// Datapath: energy integration, window sums, means and output word
`timescale 1ns / 1ps
module pewl_datapath #(
    parameter int SUM_WIDTH     = 48,
    parameter int NUM_INTERVALS = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [pewl_pkg::IN_DATA_W-1:0]   in_word,
    input  logic [15:0]                      display_interval_ms,
    input  logic [15:0]                      long_press_ms,
    input  pewl_pkg::cmd_t                   cmd,
    output pewl_pkg::stat_t                  stat,
    output logic [pewl_pkg::OUT_DATA_W-1:0]  out_word,
    output logic [1:0]                       out_kind,
    output logic                             out_last
);
    localparam logic [SUM_WIDTH-1:0] SUM_MAX = '1;

    // latched item
    logic        op_reg;
    logic [31:0] ts_reg, dur_reg;
    logic [15:0] shunt_reg, cur_reg;
    logic [12:0] bus_reg;

    logic [63:0] energy_reg;
    logic [31:0] prev_ts_reg;
    logic [SUM_WIDTH-1:0] dsum_reg [3];
    logic [SUM_WIDTH-1:0] lsum_reg [3];
    logic [31:0] dcnt_reg, lcnt_reg, dstart_reg, lstart_reg, lint_reg;
    logic [2:0]  choice_reg;
    logic        menu_reg, logging_reg;

    logic [28:0] bc_reg;     // bus * current
    logic [60:0] prod_reg;   // bus * current * delta
    logic [12:0] mb_reg;
    logic [15:0] ms_reg, mc_reg;
    logic [25:0] sup_reg;
    logic [28:0] pow_reg;
    logic [pewl_pkg::OUT_DATA_W-1:0] out_reg;
    logic [1:0]  kind_reg;
    logic        last_reg;

    logic [SUM_WIDTH-1:0] div_num;
    logic [31:0]          div_den;
    logic                 div_done;
    logic [SUM_WIDTH-1:0] div_q;
    logic [31:0]          cnt_sel, delta;
    logic [64:0]          e_sum;

    assign delta   = ts_reg - prev_ts_reg;
    assign cnt_sel = cmd.win_log ? lcnt_reg : dcnt_reg;
    assign div_num = cmd.win_log ? lsum_reg[cmd.div_sel] : dsum_reg[cmd.div_sel];
    assign div_den = (cnt_sel == 32'd0) ? 32'd1 : cnt_sel;
    assign e_sum   = {1'b0, energy_reg} + {4'd0, prod_reg};

    pewl_div #(.NUM_W(SUM_WIDTH)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .numer (div_num),
        .denom (div_den),
        .done  (div_done),
        .quot  (div_q)
    );

    function automatic logic [SUM_WIDTH-1:0] sat_add(input logic [SUM_WIDTH-1:0] s,
                                                     input logic [15:0] v);
        logic [SUM_WIDTH:0] t;
        begin
            t = {1'b0, s} + (SUM_WIDTH+1)'(v);
            sat_add = t[SUM_WIDTH] ? SUM_MAX : t[SUM_WIDTH-1:0];
        end
    endfunction

    always_comb
    begin
        stat.is_button = op_reg == pewl_pkg::OP_BUTTON;
        stat.disp_due  = (ts_reg - dstart_reg) > {16'd0, display_interval_ms};
        stat.log_due   = (ts_reg - lstart_reg) > lint_reg;
        stat.logging   = logging_reg;
        stat.div_done  = div_done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            energy_reg  <= '0;
            prev_ts_reg <= '0;
            for (int i = 0; i < 3; i++)
            begin
                dsum_reg[i] <= '0;
                lsum_reg[i] <= '0;
            end
            dcnt_reg    <= '0;
            lcnt_reg    <= '0;
            dstart_reg  <= '0;
            lstart_reg  <= '0;
            lint_reg    <= pewl_pkg::LOG_INTERVAL_RESET;
            choice_reg  <= '0;
            menu_reg    <= 1'b0;
            logging_reg <= 1'b0;
        end
        else
        begin
            if (cmd.do_button)
            begin
                if (dur_reg < {16'd0, long_press_ms})
                begin
                    if (!menu_reg)
                        logging_reg <= !logging_reg;
                    else if (32'(choice_reg) + 32'd1 >= 32'(NUM_INTERVALS))
                        choice_reg <= 3'd0;
                    else
                        choice_reg <= choice_reg + 3'd1;
                end
                else if (!menu_reg)
                begin
                    menu_reg    <= 1'b1;
                    logging_reg <= 1'b0;
                end
                else
                begin
                    menu_reg <= 1'b0;
                    lint_reg <= pewl_pkg::interval_lookup(choice_reg);
                end
            end
            if (cmd.accumulate)
            begin
                prev_ts_reg <= ts_reg;
                dsum_reg[0] <= sat_add(dsum_reg[0], {3'd0, bus_reg});
                dsum_reg[1] <= sat_add(dsum_reg[1], shunt_reg);
                dsum_reg[2] <= sat_add(dsum_reg[2], cur_reg);
                lsum_reg[0] <= sat_add(lsum_reg[0], {3'd0, bus_reg});
                lsum_reg[1] <= sat_add(lsum_reg[1], shunt_reg);
                lsum_reg[2] <= sat_add(lsum_reg[2], cur_reg);
                if (dcnt_reg != '1)
                    dcnt_reg <= dcnt_reg + 32'd1;
                if (lcnt_reg != '1)
                    lcnt_reg <= lcnt_reg + 32'd1;
            end
            if (cmd.energy_acc)
                energy_reg <= e_sum[64] ? '1 : e_sum[63:0];
            if (cmd.clear_win)
            begin
                if (cmd.win_log)
                begin
                    for (int i = 0; i < 3; i++)
                        lsum_reg[i] <= '0;
                    lcnt_reg   <= '0;
                    lstart_reg <= ts_reg;
                end
                else
                begin
                    for (int i = 0; i < 3; i++)
                        dsum_reg[i] <= '0;
                    dcnt_reg   <= '0;
                    dstart_reg <= ts_reg;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            op_reg    <= in_word[0];
            ts_reg    <= in_word[32:1];
            shunt_reg <= in_word[48:33];
            bus_reg   <= in_word[64:52];
            cur_reg   <= in_word[80:65];
            dur_reg   <= in_word[112:81];
        end
        if (cmd.load_item)
            bc_reg <= {16'd0, in_word[64:52]} * {13'd0, in_word[80:65]};
        if (cmd.energy_mul)
            prod_reg <= {32'd0, bc_reg} * {29'd0, delta};
        if (div_done && !cmd.div_start)
        begin
            case (cmd.div_sel)
                2'd0: mb_reg <= (div_q > SUM_WIDTH'(8191)) ? 13'h1FFF : div_q[12:0];
                2'd1: ms_reg <= (div_q > SUM_WIDTH'(65535)) ? 16'hFFFF : div_q[15:0];
                2'd2: mc_reg <= (div_q > SUM_WIDTH'(65535)) ? 16'hFFFF : div_q[15:0];
                default: mb_reg <= mb_reg;
            endcase
        end
        if (cmd.finish_mul)
        begin
            sup_reg <= {13'd0, mb_reg} * 26'd4040 + {10'd0, ms_reg} * 26'd10;
            pow_reg <= {16'd0, mb_reg} * {13'd0, mc_reg};
        end
    end

    // output word register; fields packed low to high
    always_ff @(posedge clk)
    begin
        if (cmd.build_out)
        begin
            last_reg <= cmd.last;
            if (cmd.do_button)
            begin
                kind_reg <= pewl_pkg::KIND_BUTTON;
                out_reg  <= {7'd0, choice_reg, 1'b0, 1'b0, energy_reg, 29'd0, 26'd0,
                             16'd0, 16'd0, 13'd0, ts_reg};
            end
            else
            begin
                kind_reg <= cmd.win_log ? pewl_pkg::KIND_LOG : pewl_pkg::KIND_DISPLAY;
                out_reg  <= {7'd0, choice_reg, menu_reg, logging_reg, energy_reg, pow_reg,
                             sup_reg, mc_reg, ms_reg, mb_reg, ts_reg};
            end
        end
    end

    // button status uses the flags after the update
    logic [pewl_pkg::OUT_DATA_W-1:0] out_fix;
    logic btn_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            btn_reg <= 1'b0;
        else if (cmd.build_out)
            btn_reg <= cmd.do_button;
    end
    always_comb
    begin
        out_fix = out_reg;
        if (btn_reg)
        begin
            out_fix[200:198] = choice_reg;
            out_fix[197]     = menu_reg;
            out_fix[196]     = logging_reg;
        end
    end

    assign out_word = out_fix;
    assign out_kind = kind_reg;
    assign out_last = last_reg;
endmodule

/* rtl/power_energy_window_logger.sv */
// Top level of the power energy window logger
//   channel | dir | handshake             | payload
//   s_axis  | in  | tvalid/tready         | tdata (112b), tuser = operation
//   m_axis  | out | tvalid/tready/tlast   | tdata (208b), tuser = record_kind
//   apb     | in  | psel/penable/pready   | display_interval_ms, long_press_ms
// A sample's closed windows are served by the shared bit-serial divider, forming the three
// means in turn. rst_n asynchronously clears the control, window and configuration state;
// the captured item and result registers are not reset. The output register holds a word
// until taken; the controller waits while it is full, so a new word is accepted once all
// but the final result of the previous one have been handed over.
`timescale 1ns / 1ps
module power_energy_window_logger #(
    parameter int SUM_WIDTH     = 48,
    parameter int NUM_INTERVALS = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // timestamp_ms, shunt_raw, bus_raw, current reading, press_duration_ms
    input  logic [111:0] s_axis_tdata,
    input  logic         s_axis_tuser,   // operation
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // record_time_ms, avg_bus_counts, avg_shunt_counts, avg_current_counts,
    // supply_microvolts, power_product, energy_total, logging_on, in_menu,
    // interval_choice, zero pad
    output logic [207:0] m_axis_tdata,
    output logic [1:0]   m_axis_tuser,   // record_kind
    output logic         m_axis_tlast,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    logic [15:0] disp_int_reg, long_press_reg;
    logic        ovalid_reg;
    logic        in_ready, in_fire;
    pewl_pkg::cmd_t  cmd;
    pewl_pkg::stat_t stat;
    logic [pewl_pkg::OUT_DATA_W-1:0] out_word;
    logic [1:0] out_kind;
    logic       out_last;

    assign pready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            disp_int_reg   <= pewl_pkg::DISP_INTERVAL_RESET;
            long_press_reg <= pewl_pkg::LONG_PRESS_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr)
                pewl_pkg::ADDR_DISP_INTERVAL: disp_int_reg   <= pwdata[15:0];
                pewl_pkg::ADDR_LONG_PRESS:    long_press_reg <= pwdata[15:0];
                default:                      disp_int_reg   <= disp_int_reg;
            endcase
        end
    end
    always_comb
    begin
        case (paddr)
            pewl_pkg::ADDR_DISP_INTERVAL: prdata = {16'd0, disp_int_reg};
            pewl_pkg::ADDR_LONG_PRESS:    prdata = {16'd0, long_press_reg};
            default:                      prdata = 32'd0;
        endcase
    end

    assign s_axis_tready = in_ready;
    assign in_fire       = s_axis_tvalid && in_ready;

    pewl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .out_busy (ovalid_reg && !m_axis_tready),
        .stat     (stat),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    pewl_datapath #(
        .SUM_WIDTH     (SUM_WIDTH),
        .NUM_INTERVALS (NUM_INTERVALS)
    ) u_dp (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_word             ({s_axis_tdata, s_axis_tuser}),
        .display_interval_ms (disp_int_reg),
        .long_press_ms       (long_press_reg),
        .cmd                 (cmd),
        .stat                (stat),
        .out_word            (out_word),
        .out_kind            (out_kind),
        .out_last            (out_last)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovalid_reg <= 1'b0;
        else if (cmd.build_out)
            ovalid_reg <= 1'b1;
        else if (m_axis_tready)
            ovalid_reg <= 1'b0;
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = out_word;
    assign m_axis_tuser  = out_kind;
    assign m_axis_tlast  = out_last;
endmodule

/* rtl/pewl_checker.sv */
// Port-level checker for the logger, bound to the top level
`timescale 1ns / 1ps
`include "power_energy_window_logger_assert.svh"
module pewl_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [1:0]   m_axis_tuser,
    input logic         m_axis_tlast,
    input logic [207:0] m_axis_tdata
);
    logic out_wait;
    assign out_wait = m_axis_tvalid && !m_axis_tready;

    `PEWL_ASSERT_NEXT(a_hold, out_wait, m_axis_tvalid && $stable(m_axis_tdata))
    `PEWL_ASSERT_NEXT(a_meta_hold, out_wait, $stable(m_axis_tuser) && $stable(m_axis_tlast))
    `PEWL_ASSERT_IMPL(a_kind, m_axis_tvalid, m_axis_tuser <= pewl_pkg::KIND_BUTTON)
    `PEWL_ASSERT_IMPL(a_btn_last, m_axis_tvalid && m_axis_tuser == pewl_pkg::KIND_BUTTON, m_axis_tlast)
endmodule

bind power_energy_window_logger pewl_checker u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tdata  (m_axis_tdata)
);

/* verif/power_energy_window_logger_test.sv */
// Testbench for the power energy window logger: directed and random stream traffic checked against a predictor
`timescale 1ns / 1ps
module power_energy_window_logger_test;

    typedef struct packed {
        logic [1:0]  kind;
        logic        last;
        logic [31:0] rtime;
        logic [12:0] abus;
        logic [15:0] ashunt;
        logic [15:0] acur;
        logic [25:0] supply;
        logic [28:0] power;
        logic [63:0] energy;
        logic        logging;
        logic        menu;
        logic [2:0]  choice;
    } record_t;

    class logger_scoreboard;
        logic [15:0] disp_ivl, long_ms;
        logic [63:0] energy;
        logic [31:0] prev_ts;
        logic [63:0] dsum [3];
        logic [31:0] dcnt, dstart;
        logic [63:0] lsum [3];
        logic [31:0] lcnt, lstart, log_ivl;
        logic [2:0]  choice;
        logic        menu, logging;
        record_t     pending[$];
        int          errors;

        function new();
            disp_ivl = pewl_pkg::DISP_INTERVAL_RESET;
            long_ms  = pewl_pkg::LONG_PRESS_RESET;
            energy = 0; prev_ts = 0;
            dcnt = 0; dstart = 0; lcnt = 0; lstart = 0;
            log_ivl = pewl_pkg::LOG_INTERVAL_RESET;
            choice = 0; menu = 0; logging = 0; errors = 0;
            for (int i = 0; i < 3; i++)
            begin
                dsum[i] = 0;
                lsum[i] = 0;
            end
        endfunction

        function record_t status(logic [1:0] kind, logic [31:0] ts);
            record_t r;
            r = '0;
            r.kind = kind; r.rtime = ts; r.energy = energy;
            r.logging = logging; r.menu = menu; r.choice = choice;
            return r;
        endfunction

        function record_t window_mean(logic [1:0] kind, logic [31:0] ts,
                                      logic [63:0] s0, logic [63:0] s1,
                                      logic [63:0] s2, logic [31:0] cnt);
            record_t r;
            logic [63:0] n, b, s, c;
            n = (cnt == 0) ? 64'd1 : 64'(cnt);
            b = s0 / n; s = s1 / n; c = s2 / n;
            if (b > 8191) b = 8191;
            if (s > 65535) s = 65535;
            if (c > 65535) c = 65535;
            r = status(kind, ts);
            r.abus = b[12:0]; r.ashunt = s[15:0]; r.acur = c[15:0];
            r.supply = 26'(b * 4040 + s * 10);
            r.power  = 29'(b * c);
            return r;
        endfunction

        function logic [63:0] sat48(logic [63:0] a, logic [63:0] v);
            logic [63:0] m;
            m = 64'hFFFF_FFFF_FFFF;
            return (a > m || v > m - a) ? m : a + v;
        endfunction

        function void note_word(logic op, logic [31:0] ts, logic [15:0] shunt,
                                logic [15:0] bus, logic [15:0] cur, logic [31:0] dur);
            logic [63:0] v [3];
            logic [63:0] prod;
            logic [31:0] delta;
            int first;
            record_t r;
            if (op == pewl_pkg::OP_BUTTON)
            begin
                if (dur < 32'(long_ms))
                begin
                    if (!menu) logging = !logging;
                    else choice = choice + 1;
                end
                else if (!menu)
                begin
                    menu = 1; logging = 0;
                end
                else
                begin
                    menu = 0; log_ivl = pewl_pkg::interval_lookup(choice);
                end
                r = status(pewl_pkg::KIND_BUTTON, ts);
                r.last = 1;
                pending.push_back(r);
                return;
            end
            v[0] = 64'(bus >> 3); v[1] = 64'(shunt); v[2] = 64'(cur);
            delta = ts - prev_ts;
            prod = v[0] * v[2] * 64'(delta);
            energy = (prod > ~energy) ? '1 : energy + prod;
            prev_ts = ts;
            for (int i = 0; i < 3; i++)
            begin
                dsum[i] = sat48(dsum[i], v[i]);
                lsum[i] = sat48(lsum[i], v[i]);
            end
            if (dcnt != '1) dcnt++;
            if (lcnt != '1) lcnt++;
            first = pending.size();
            if (ts - dstart > 32'(disp_ivl))
            begin
                pending.push_back(window_mean(pewl_pkg::KIND_DISPLAY, ts,
                                              dsum[0], dsum[1], dsum[2], dcnt));
                for (int i = 0; i < 3; i++) dsum[i] = 0;
                dcnt = 0; dstart = ts;
            end
            if (ts - lstart > log_ivl)
            begin
                if (logging)
                    pending.push_back(window_mean(pewl_pkg::KIND_LOG, ts,
                                                  lsum[0], lsum[1], lsum[2], lcnt));
                for (int i = 0; i < 3; i++) lsum[i] = 0;
                lcnt = 0; lstart = ts;
            end
            if (pending.size() > first)
                pending[pending.size() - 1].last = 1;
        endfunction

        function void check_word(record_t got);
            record_t exp_r;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10) $display("unexpected word %h", got);
                return;
            end
            exp_r = pending.pop_front();
            if (got !== exp_r)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected %h actual %h", exp_r, got);
            end
        endfunction
    endclass

    logic         clk, rst_n;
    logic         s_axis_tvalid, s_axis_tready, s_axis_tuser;
    logic [111:0] s_axis_tdata;
    logic         m_axis_tvalid, m_axis_tready, m_axis_tlast;
    logic [207:0] m_axis_tdata;
    logic [1:0]   m_axis_tuser;
    logic         psel, penable, pwrite, pready;
    logic [2:0]   paddr;
    logic [31:0]  pwdata, prdata;

    logger_scoreboard board;
    logic [31:0] now_ms;
    bit          hold_off;
    bit          sink_busy;

    power_energy_window_logger dut (.*);

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("FAILED: results differ");
        $finish;
    end

    // output side: random stalls, plus one long hold-off when requested
    initial
    begin
        int gap;
        m_axis_tready = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                m_axis_tready <= 0;
                for (int i = 0; i < 400; i++) @(posedge clk);
                hold_off = 0;
            end
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) :
                  (($urandom_range(0, 2) == 0) ? $urandom_range(0, 3) : 0);
            if (sink_busy) gap = 0;
            if (gap > 0)
            begin
                m_axis_tready <= 0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1;
        end
    end

    always @(posedge clk)
    begin
        record_t r;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            r.kind = m_axis_tuser; r.last = m_axis_tlast;
            {r.choice, r.menu, r.logging, r.energy, r.power, r.supply,
             r.acur, r.ashunt, r.abus, r.rtime} = m_axis_tdata[200:0];
            board.check_word(r);
        end
    end

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] value);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= value;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        if (addr == pewl_pkg::ADDR_DISP_INTERVAL) board.disp_ivl = value[15:0];
        else if (addr == pewl_pkg::ADDR_LONG_PRESS) board.long_ms = value[15:0];
    endtask

    task automatic send_word(input logic op, input logic [31:0] ts, input logic [15:0] shunt,
                             input logic [15:0] bus, input logic [15:0] cur,
                             input logic [31:0] dur);
        int gap;
        gap = ($urandom_range(0, 14) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 1);
        if (gap > 0)
        begin
            s_axis_tvalid <= 0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tuser <= op;
        s_axis_tdata <= {dur, cur, bus, shunt, ts};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        board.note_word(op, ts, shunt, bus, cur, dur);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        s_axis_tvalid <= 0;
        sink_busy = 1;
        while (board.pending.size() != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (200) @(posedge clk);
        sink_busy = 0;
    endtask

    task automatic sample(input logic [31:0] step);
        now_ms = now_ms + step;
        send_word(pewl_pkg::OP_SAMPLE, now_ms, $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic press(input logic [31:0] dur);
        send_word(pewl_pkg::OP_BUTTON, $urandom, $urandom, $urandom, $urandom, dur);
    endtask

    task automatic random_phase(input int count);
        int pick;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
                press($urandom_range(0, 1) ? $urandom_range(0, 800) : $urandom);
            else if (pick < 12)
                sample($urandom);
            else
                sample($urandom_range(0, 300));
        end
    endtask

    initial
    begin
        board = new();
        now_ms = 0; hold_off = 0; sink_busy = 0;
        rst_n = 0;
        s_axis_tvalid = 0; s_axis_tdata = '0; s_axis_tuser = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: field extremes, presses through the menu, timestamp wrap
        send_word(pewl_pkg::OP_SAMPLE, 32'd0, 16'h0000, 16'h0000, 16'h0000, 32'd0);
        send_word(pewl_pkg::OP_SAMPLE, 32'd501, 16'hFFFF, 16'hFFFF, 16'hFFFF, '1);
        press(32'd0);
        send_word(pewl_pkg::OP_SAMPLE, 32'd1100, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'd0);
        press(32'd399);
        press(32'd400);
        press(32'd1);
        press(32'd1);
        press(32'hFFFF_FFFF);
        press(32'd5);
        send_word(pewl_pkg::OP_SAMPLE, 32'hFFFF_FFF0, 16'h1234, 16'hFFF8, 16'hFFFF, 32'd0);
        send_word(pewl_pkg::OP_SAMPLE, 32'd20, 16'h5555, 16'hAAAA, 16'h5555, 32'd0);
        send_word(pewl_pkg::OP_SAMPLE, 32'd10, 16'hAAAA, 16'h5555, 16'hAAAA, 32'd0);
        send_word(pewl_pkg::OP_SAMPLE, 32'h8000_0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'd0);
        send_word(pewl_pkg::OP_SAMPLE, 32'h0000_0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'd0);
        now_ms = 0;
        drain();

        reg_write(pewl_pkg::ADDR_DISP_INTERVAL, 32'd0);
        reg_write(pewl_pkg::ADDR_LONG_PRESS, 32'd0);
        random_phase(120);
        drain();

        reg_write(pewl_pkg::ADDR_DISP_INTERVAL, 32'hFFFF);
        reg_write(pewl_pkg::ADDR_LONG_PRESS, 32'hFFFF);
        random_phase(120);
        drain();

        // receiver stalls long while the sender keeps offering
        reg_write(pewl_pkg::ADDR_DISP_INTERVAL, 32'd50);
        reg_write(pewl_pkg::ADDR_LONG_PRESS, 32'd300);
        hold_off = 1;
        random_phase(40);
        drain();

        reg_write(pewl_pkg::ADDR_DISP_INTERVAL, $urandom_range(0, 2000));
        reg_write(pewl_pkg::ADDR_LONG_PRESS, $urandom_range(0, 1000));
        random_phase(400);
        drain();

        if (board.errors == 0 && board.pending.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule
